### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sndalu_pkg.sv
// ---------------------------------------------------------------------------
// sndalu_pkg
// Types and constants of the seconds/nanoseconds duration unit.
// ---------------------------------------------------------------------------
package sndalu_pkg;

    localparam int SEC_W = 32;
    localparam int NS_W  = 30;
    localparam int TOT_W = 62;

    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_US  = 3'd4;
    localparam logic [2:0] ACT_MS  = 3'd5;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEC_W-1:0] a_seconds;
        logic [NS_W-1:0]  a_nanos;
        logic [SEC_W-1:0] b_seconds;
        logic [NS_W-1:0]  b_nanos;
        logic [SEC_W-1:0] scalar;
    } t_req;

    typedef struct packed {
        logic [SEC_W-1:0] res_seconds;
        logic [NS_W-1:0]  res_nanos;
        logic             div_zero;
    } t_res;

    typedef struct packed {
        logic [TOT_W-1:0] ns_total;
        logic [SEC_W-1:0] sec_base;
        logic             div_zero;
        logic             is_div;
    } t_split;

    typedef struct packed {
        logic [SEC_W-1:0] sec_base;
        logic             div_zero;
    } t_fin;

endpackage

### rtl/sec_nsec_duration_alu_top.sv
// Throughput: one transfer per cycle; o_busy stays low.
// Depth is set by the 62-stage bit-per-stage divider of the general divide;
// the nanosecond split by 1e9 is a three-stage reciprocal multiply.
// Reset: synchronous, active low; clears the valid bits, payload is not reset.
// ---------------------------------------------------------------------------
// sec_nsec_duration_alu_top
// Add, subtract, scale, divide and convert seconds/nanoseconds durations.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sec_nsec_duration_alu_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sndalu_pkg::t_req  i_req,
    output logic              o_busy,
    output logic              o_done,
    output sndalu_pkg::t_res  o_res
);

    localparam int TOT_W   = sndalu_pkg::TOT_W;
    localparam int SEC_W   = sndalu_pkg::SEC_W;
    localparam int NS_W    = sndalu_pkg::NS_W;
    localparam int LATENCY = TOT_W + 6;

    localparam logic [SEC_W-1:0] RECIP_E9 = 32'd2305843009;
    localparam logic [SEC_W:0]   E9_1     = 33'd1000000000;
    localparam logic [SEC_W:0]   E9_2     = 33'd2000000000;
    localparam logic [SEC_W:0]   E9_3     = 33'd3000000000;
    localparam logic [SEC_W:0]   E9_4     = 33'd4000000000;

    logic                  r_v1;
    sndalu_pkg::t_req      r_req1;
    logic                  r_v2;
    sndalu_pkg::t_req      r_req2;
    logic [TOT_W-1:0]      r_an_k;
    logic [SEC_W-1:0]      r_as_k;
    logic [TOT_W-1:0]      r_as_e9;
    logic [41:0]           r_us;
    logic [51:0]           r_ms;

    sndalu_pkg::t_split    n_split;
    logic [TOT_W-1:0]      n_dividend;
    logic                  d1_v;
    logic [TOT_W-1:0]      d1_quo;
    sndalu_pkg::t_split    d1_tag;
    logic [TOT_W-1:0]      n_total;
    sndalu_pkg::t_fin      n_fin;

    logic [2*SEC_W-1:0]    n_s1_prod;
    logic                  r_s1_v;
    logic [TOT_W-1:0]      r_s1_x;
    logic [SEC_W:0]        r_s1_est;
    sndalu_pkg::t_fin      r_s1_fin;
    logic [TOT_W-1:0]      n_s2_diff;
    logic                  r_s2_v;
    logic [SEC_W:0]        r_s2_est;
    logic [SEC_W:0]        r_s2_rem;
    sndalu_pkg::t_fin      r_s2_fin;
    logic [SEC_W:0]        n_s3_quo;
    logic [SEC_W:0]        n_s3_nrm;
    logic                  r_s3_v;
    logic [SEC_W:0]        r_s3_quo;
    logic [NS_W-1:0]       r_s3_rem;
    sndalu_pkg::t_fin      r_s3_fin;

    logic                  r_done;
    sndalu_pkg::t_res      r_res;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start && !o_busy;
            r_v2   <= r_v1;
            r_s1_v <= d1_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_done <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req1  <= i_req;
        r_req2  <= r_req1;
        r_an_k  <= TOT_W'(r_req1.a_nanos) * TOT_W'(r_req1.scalar);
        r_as_k  <= r_req1.a_seconds * r_req1.scalar;
        r_as_e9 <= TOT_W'(r_req1.a_seconds) * TOT_W'(sndalu_pkg::NS_PER_SEC);
        r_us    <= 42'(r_req1.scalar) * 42'd1000;
        r_ms    <= 52'(r_req1.scalar) * 52'd1000000;
    end

    always_comb begin
        logic             a_ov;
        logic             b_ov;
        logic [SEC_W-1:0] asn;
        logic [SEC_W-1:0] bsn;
        logic [NS_W-1:0]  ann;
        logic [NS_W-1:0]  bnn;
        logic [NS_W:0]    rn;
        logic [SEC_W-1:0] rs;
        a_ov = r_req2.a_nanos >= sndalu_pkg::NS_PER_SEC;
        b_ov = r_req2.b_nanos >= sndalu_pkg::NS_PER_SEC;
        asn  = r_req2.a_seconds + SEC_W'(a_ov);
        bsn  = r_req2.b_seconds + SEC_W'(b_ov);
        ann  = a_ov ? r_req2.a_nanos - sndalu_pkg::NS_PER_SEC : r_req2.a_nanos;
        bnn  = b_ov ? r_req2.b_nanos - sndalu_pkg::NS_PER_SEC : r_req2.b_nanos;
        if (ann < bnn) begin
            rs = asn - bsn - SEC_W'(1);
            rn = (NS_W+1)'(ann) + (NS_W+1)'(sndalu_pkg::NS_PER_SEC) - (NS_W+1)'(bnn);
        end else begin
            rs = asn - bsn;
            rn = (NS_W+1)'(ann) - (NS_W+1)'(bnn);
        end
        n_dividend = r_as_e9 + TOT_W'(r_req2.a_nanos);
        n_split    = '0;
        case (r_req2.action)
            sndalu_pkg::ACT_ADD: begin
                n_split.ns_total = TOT_W'(r_req2.a_nanos) + TOT_W'(r_req2.b_nanos);
                n_split.sec_base = r_req2.a_seconds + r_req2.b_seconds;
            end
            sndalu_pkg::ACT_SUB: begin
                n_split.ns_total = TOT_W'(rn);
                n_split.sec_base = rs;
            end
            sndalu_pkg::ACT_MUL: begin
                n_split.ns_total = r_an_k;
                n_split.sec_base = r_as_k;
            end
            sndalu_pkg::ACT_DIV: begin
                if (r_req2.scalar == '0) begin
                    n_split.div_zero = 1'b1;
                end else begin
                    n_split.is_div = 1'b1;
                end
            end
            sndalu_pkg::ACT_US: begin
                n_split.ns_total = TOT_W'(r_us);
            end
            sndalu_pkg::ACT_MS: begin
                n_split.ns_total = TOT_W'(r_ms);
            end
            default: begin
                n_split = '0;
            end
        endcase
    end

    sndalu_div #(
        .DW (TOT_W),
        .VW (SEC_W),
        .TW ($bits(sndalu_pkg::t_split))
    ) u_div_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_num   (n_dividend),
        .i_den   (r_req2.scalar),
        .i_tag   (n_split),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    always_comb begin
        n_total        = d1_tag.is_div ? d1_quo : d1_tag.ns_total;
        n_fin.sec_base = d1_tag.sec_base;
        n_fin.div_zero = d1_tag.div_zero;
    end

    // estimate the quotient by 1e9 from the top 32 bits; low by at most four
    assign n_s1_prod = (2*SEC_W)'(n_total[TOT_W-1:NS_W]) * (2*SEC_W)'(RECIP_E9);

    always_ff @(posedge i_clk) begin
        r_s1_x   <= n_total;
        r_s1_est <= n_s1_prod[2*SEC_W-1:SEC_W-1];
        r_s1_fin <= n_fin;
    end

    assign n_s2_diff = r_s1_x - TOT_W'(r_s1_est) * TOT_W'(sndalu_pkg::NS_PER_SEC);

    always_ff @(posedge i_clk) begin
        r_s2_est <= r_s1_est;
        r_s2_rem <= n_s2_diff[SEC_W:0];
        r_s2_fin <= r_s1_fin;
    end

    always_comb begin
        if (r_s2_rem >= E9_4) begin
            n_s3_quo = r_s2_est + (SEC_W+1)'(4);
            n_s3_nrm = r_s2_rem - E9_4;
        end else if (r_s2_rem >= E9_3) begin
            n_s3_quo = r_s2_est + (SEC_W+1)'(3);
            n_s3_nrm = r_s2_rem - E9_3;
        end else if (r_s2_rem >= E9_2) begin
            n_s3_quo = r_s2_est + (SEC_W+1)'(2);
            n_s3_nrm = r_s2_rem - E9_2;
        end else if (r_s2_rem >= E9_1) begin
            n_s3_quo = r_s2_est + (SEC_W+1)'(1);
            n_s3_nrm = r_s2_rem - E9_1;
        end else begin
            n_s3_quo = r_s2_est;
            n_s3_nrm = r_s2_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_quo <= n_s3_quo;
        r_s3_rem <= n_s3_nrm[NS_W-1:0];
        r_s3_fin <= r_s2_fin;
    end

    always_ff @(posedge i_clk) begin
        r_res.res_seconds <= r_s3_fin.sec_base + r_s3_quo[SEC_W-1:0];
        r_res.res_nanos   <= r_s3_rem;
        r_res.div_zero    <= r_s3_fin.div_zero;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_IMP(a_ns_norm, i_clk, i_rst_n, o_done, o_res.res_nanos < sndalu_pkg::NS_PER_SEC)
    `ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_done && o_res.div_zero,
                o_res.res_seconds == '0 && o_res.res_nanos == '0)
    `ASSERT_IMP(a_latency, i_clk, i_rst_n, i_start && !o_busy, ##(LATENCY) o_done)

endmodule

### rtl/sndalu_div.sv
// ---------------------------------------------------------------------------
// sndalu_div
// Pipelined restoring divider, one quotient bit per stage, side tag carried.
// ---------------------------------------------------------------------------
module sndalu_div #(
    parameter int DW = 62,
    parameter int VW = 32,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [DW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_v;
    logic [DW-1:0] n_v;
    logic [VW-1:0] r_rem [DW];
    logic [VW-1:0] n_rem [DW];
    logic [DW-1:0] r_num [DW];
    logic [DW-1:0] n_num [DW];
    logic [VW-1:0] r_den [DW];
    logic [TW-1:0] r_tag [DW];
    logic [VW-1:0] c_rem [DW];
    logic [DW-1:0] c_num [DW];
    logic [VW-1:0] c_den [DW];
    logic [TW-1:0] c_tag [DW];
    logic [DW-1:0] c_v;

    always_comb begin
        logic [VW:0] sh;
        c_rem[0] = '0;
        c_num[0] = i_num;
        c_den[0] = i_den;
        c_tag[0] = i_tag;
        c_v[0]   = i_valid;
        for (int s = 1; s < DW; s++) begin
            c_rem[s] = r_rem[s-1];
            c_num[s] = r_num[s-1];
            c_den[s] = r_den[s-1];
            c_tag[s] = r_tag[s-1];
            c_v[s]   = r_v[s-1];
        end
        for (int s = 0; s < DW; s++) begin
            sh = {c_rem[s], c_num[s][DW-1]};
            if (sh >= {1'b0, c_den[s]}) begin
                n_rem[s] = VW'(sh - {1'b0, c_den[s]});
                n_num[s] = {c_num[s][DW-2:0], 1'b1};
            end else begin
                n_rem[s] = sh[VW-1:0];
                n_num[s] = {c_num[s][DW-2:0], 1'b0};
            end
            n_v[s] = c_v[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DW; s++) begin
            r_rem[s] <= n_rem[s];
            r_num[s] <= n_num[s];
            r_den[s] <= c_den[s];
            r_tag[s] <= c_tag[s];
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_quo   = r_num[DW-1];
    assign o_tag   = r_tag[DW-1];

endmodule
